// ===== hdl/cdq_pkg.sv =====
// cdq_pkg: shared codes, widths and types for the circular deque.
// No dependencies; compiled first.
package cdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int CAP_W    = 5;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // register word index
  localparam logic [APB_AW-3:0] REG_CAPACITY = '0;

  typedef enum logic [FUNC_W-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_STATUS     = 3'd4
  } cdq_func_t;

  // per-cell select lines, decoded in the top level
  typedef struct packed {
    logic wr;        // store write word this cycle
    logic head_hit;  // cell holds the front after the operation
    logic tail_hit;  // cell holds the rear after the operation
  } cdq_cell_ctl_t;

endpackage

// ===== hdl/cdq_in_if.sv =====
// cdq_in_if: operation channel (valid/ready plus func and item_value).
// Depends on cdq_pkg.
interface cdq_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                              valid;
  logic                              ready;
  logic [cdq_pkg::FUNC_W-1:0]        func;
  logic signed [VALUE_WIDTH-1:0]     item_value;

  modport source (output valid, output func, output item_value, input ready);
  modport sink   (input valid, input func, input item_value, output ready);
endinterface

// ===== hdl/cdq_out_if.sv =====
// cdq_out_if: result channel (valid/ready plus status word).
// No package dependencies.
interface cdq_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic                          success;
  logic signed [VALUE_WIDTH-1:0] front_value;
  logic signed [VALUE_WIDTH-1:0] rear_value;
  logic                          is_empty;
  logic                          is_full;

  modport source (output valid, output success, output front_value, output rear_value,
                  output is_empty, output is_full, input ready);
  modport sink   (input valid, input success, input front_value, input rear_value,
                  input is_empty, input is_full, output ready);
endinterface

// ===== hdl/cdq_cell.sv =====
// cdq_cell: one ring entry; stores a word and taps the front/rear read chain.
// Depends on cdq_pkg (cdq_cell_ctl_t).
module cdq_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cdq_pkg::cdq_cell_ctl_t ctl,
  input  logic [VALUE_WIDTH-1:0] wdata,
  input  logic [VALUE_WIDTH-1:0] front_in,
  input  logic [VALUE_WIDTH-1:0] rear_in,
  output logic [VALUE_WIDTH-1:0] front_out,
  output logic [VALUE_WIDTH-1:0] rear_out
);

  logic [VALUE_WIDTH-1:0] data;
  logic [VALUE_WIDTH-1:0] fwd;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      data <= wdata;
    end
  end

  // word written this cycle is seen by the result at once
  assign fwd       = ctl.wr ? wdata : data;
  assign front_out = ctl.head_hit ? fwd : front_in;
  assign rear_out  = ctl.tail_hit ? fwd : rear_in;

endmodule

// ===== hdl/circular_deque.sv =====
// circular_deque: bounded double-ended queue over a row of storage cells.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if and cdq_cell.
//
// Usage:
//   in_ch  carries one operation word: func (0 push front, 1 push back,
//          2 pop front, 3 pop back, 4..7 status only) and item_value.
//   out_ch returns exactly one status word per operation: success,
//          front_value, rear_value (all ones when empty), is_empty, is_full.
//   APB    register 0 (byte address 0) is capacity, 5 bits, reset 16;
//          0 acts as 1, values above MAX_DEPTH act as MAX_DEPTH.
//          Change it only while no operation is in flight.
// Latency: the status word is valid the cycle after the operation is taken.
// Throughput: one operation per cycle while out_ch is ready. The pointer update,
//   the cell write and the front/rear pick through the cell chain all settle
//   together, so the chain length (MAX_DEPTH cells) sets the critical path.
// Stall: the result sits in an output register; a new operation is taken
//   in the same cycle the waiting word leaves, otherwise in_ch.ready drops.
// Reset (rst, synchronous): pointers to 0, deque empty, capacity 16,
//   output register empty. Cell contents are not cleared; an entry is
//   only read after it is written.
module circular_deque #(
  parameter int MAX_DEPTH   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  cdq_in_if.sink                      in_ch,
  cdq_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cdq_pkg::APB_AW-1:0]  paddr,
  input  logic [cdq_pkg::APB_DW-1:0]  pwdata,
  output logic [cdq_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);

  // pointer width and width that holds MAX_DEPTH itself
  localparam int PW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int EW = (CW > cdq_pkg::CAP_W) ? CW : cdq_pkg::CAP_W;

  // ---------------------------------------------------------------- config
  logic [cdq_pkg::CAP_W-1:0] capacity;
  logic                      cfg_wr;
  logic                      reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[cdq_pkg::APB_AW-1:2] == cdq_pkg::REG_CAPACITY);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? cdq_pkg::APB_DW'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cdq_pkg::CAP_RESET;
    end else if (cfg_wr) begin
      capacity <= pwdata[cdq_pkg::CAP_W-1:0];
    end
  end

  // clamp capacity into 1..MAX_DEPTH
  logic [EW-1:0] cap_ext;
  logic [CW-1:0] cap_eff;

  assign cap_ext = EW'(capacity);

  always_comb begin
    priority if (capacity == '0) begin
      cap_eff = CW'(1);
    end else if (cap_ext > EW'(MAX_DEPTH)) begin
      cap_eff = CW'(MAX_DEPTH);
    end else begin
      cap_eff = CW'(cap_ext);
    end
  end

  // ------------------------------------------------------- pointer helpers
  function automatic logic [PW-1:0] step_up(input logic [PW-1:0] p,
                                            input logic [CW-1:0] c);
    logic [CW:0] s;
    s = (CW+1)'(p) + (CW+1)'(1);
    step_up = (s >= (CW+1)'(c)) ? '0 : PW'(s);
  endfunction

  function automatic logic [PW-1:0] step_down(input logic [PW-1:0] p,
                                              input logic [CW-1:0] c);
    step_down = (p == '0 || CW'(p) > c) ? PW'(c - CW'(1)) : p - PW'(1);
  endfunction

  // ---------------------------------------------------------- deque state
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic          empty_flag;
  logic [PW-1:0] head_next;
  logic [PW-1:0] tail_next;
  logic          empty_next;
  logic          ok;
  logic          we;
  logic [PW-1:0] waddr;
  logic          full_now;
  logic          full_next;
  logic          accept;

  assign accept   = in_ch.valid && in_ch.ready;
  assign full_now = !empty_flag && (step_up(tail, cap_eff) == head);

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty_flag;
    ok         = 1'b1;
    we         = 1'b0;
    waddr      = '0;
    unique case (in_ch.func)
      cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_BACK: begin
        priority if (empty_flag) begin
          // first word always lands in entry 0
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          we         = 1'b1;
          waddr      = '0;
        end else if (full_now) begin
          ok = 1'b0;
        end else if (in_ch.func == cdq_pkg::FN_PUSH_FRONT) begin
          head_next = step_down(head, cap_eff);
          we        = 1'b1;
          waddr     = head_next;
        end else begin
          tail_next = step_up(tail, cap_eff);
          we        = 1'b1;
          waddr     = tail_next;
        end
      end
      cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_BACK: begin
        priority if (empty_flag) begin
          ok = 1'b0;
        end else if (head == tail) begin
          // last entry leaves: back to the reset pointers
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b1;
        end else if (in_ch.func == cdq_pkg::FN_POP_FRONT) begin
          head_next = step_up(head, cap_eff);
        end else begin
          tail_next = step_down(tail, cap_eff);
        end
      end
      default: begin
        // status only, also the unused codes
      end
    endcase
  end

  assign full_next = !empty_next && (step_up(tail_next, cap_eff) == head_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      tail       <= '0;
      empty_flag <= 1'b1;
    end else if (accept) begin
      head       <= head_next;
      tail       <= tail_next;
      empty_flag <= empty_next;
    end
  end

  // ------------------------------------------------------------ cell row
  // front/rear words ripple from cell 0 to the last cell; the cell whose
  // index matches the new head (tail) substitutes its word.
  logic [VALUE_WIDTH-1:0] front_link [0:MAX_DEPTH];
  logic [VALUE_WIDTH-1:0] rear_link  [0:MAX_DEPTH];

  assign front_link[0] = '1;
  assign rear_link[0]  = '1;

  for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_cell
    cdq_pkg::cdq_cell_ctl_t ctl;

    assign ctl.wr       = accept && we && (waddr == PW'(i));
    assign ctl.head_hit = (head_next == PW'(i));
    assign ctl.tail_hit = (tail_next == PW'(i));

    cdq_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .wdata     (in_ch.item_value),
      .front_in  (front_link[i]),
      .rear_in   (rear_link[i]),
      .front_out (front_link[i+1]),
      .rear_out  (rear_link[i+1])
    );
  end

  // ------------------------------------------------------- output register
  logic out_valid;

  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.success     <= ok;
      out_ch.front_value <= empty_next ? '1 : front_link[MAX_DEPTH];
      out_ch.rear_value  <= empty_next ? '1 : rear_link[MAX_DEPTH];
      out_ch.is_empty    <= empty_next;
      out_ch.is_full     <= full_next;
    end
  end

  // ------------------------------------------------------------ assertions
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_ch.valid)
    else $error("result word missing after accepted operation");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !(out_ch.is_empty && out_ch.is_full))
    else $error("result reports both empty and full");

  a_empty_values: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.is_empty) |->
      (out_ch.front_value == '1 && out_ch.rear_value == '1))
    else $error("empty result carries stored values");

  a_refused_push: assert property (@(posedge clk) disable iff (rst)
    (accept && !ok && (in_ch.func == cdq_pkg::FN_PUSH_FRONT ||
                       in_ch.func == cdq_pkg::FN_PUSH_BACK)) |=> out_ch.is_full)
    else $error("push refused while deque not full");

endmodule

// ===== verif/circular_deque_tb.sv =====
// circular_deque_tb: self-checking bench for the circular deque.
// Drives operation words, predicts the status word for each one and checks it.
// Depends on cdq_pkg, cdq_in_if, cdq_out_if and circular_deque.
`timescale 1ns / 1ps

module circular_deque_tb;

  localparam int DEPTH = 16;
  localparam int VW    = 32;
  localparam int FW    = cdq_pkg::FUNC_W;
  localparam int CPW   = cdq_pkg::CAP_W;
  localparam int AW    = cdq_pkg::APB_AW;
  localparam int DW    = cdq_pkg::APB_DW;
  // far past the slowest legal run (both sides idling)
  localparam int unsigned TIMEOUT_NS = 800_000;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [FW-1:0] func;
    logic [VW-1:0] value;
  } op_word_t;

  typedef struct packed {
    logic          success;
    logic [VW-1:0] front_value;
    logic [VW-1:0] rear_value;
    logic          is_empty;
    logic          is_full;
  } status_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // APB side; writes only, pready is expected to stay high
  logic          psel    = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite  = 1'b0;
  logic [AW-1:0] paddr   = '0;
  logic [DW-1:0] pwdata  = '0;
  logic [DW-1:0] prdata;
  logic          pready;

  cdq_in_if  #(.VALUE_WIDTH(VW)) op_if ();
  cdq_out_if #(.VALUE_WIDTH(VW)) status_if ();

  circular_deque #(
    .MAX_DEPTH   (DEPTH),
    .VALUE_WIDTH (VW)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (op_if),
    .out_ch  (status_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow deque: same pointers, flag and store as the block. Pointers stay
  // below DEPTH, so they index the store directly.
  // ---------------------------------------------------------------------------
  logic [VW-1:0]  dq_store [DEPTH];
  int unsigned    dq_head  = 0;
  int unsigned    dq_tail  = 0;
  bit             dq_empty = 1'b1;
  logic [CPW-1:0] cap_reg  = cdq_pkg::CAP_RESET;

  op_word_t     pending_ops [$];   // words waiting for the driver
  status_word_t status_due  [$];   // predicted status words, oldest first

  int n_fail        = 0;
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  bit op_taken      = 1'b0;        // handshake seen at the last rising edge

  // 0 behaves as 1, anything above the built depth as the built depth
  function automatic int unsigned usable_depth();
    if (cap_reg == 0) return 1;
    if (cap_reg > DEPTH) return DEPTH;
    return 32'(cap_reg);
  endfunction

  function automatic int unsigned ring_up(int unsigned p, int unsigned c);
    return (p + 1 >= c) ? 0 : p + 1;
  endfunction

  // a pointer left beyond a shrunken capacity also lands on the last slot
  function automatic int unsigned ring_down(int unsigned p, int unsigned c);
    return (p == 0 || p > c) ? c - 1 : p - 1;
  endfunction

  function automatic bit at_capacity(int unsigned c);
    return !dq_empty && ring_up(dq_tail, c) == dq_head;
  endfunction

  // Apply one operation to the shadow deque and return the status word it
  // should produce. Codes past FN_STATUS fall into the default: status only.
  function automatic status_word_t status_after_op(op_word_t op);
    status_word_t r;
    int unsigned  c;
    c = usable_depth();
    r.success = 1'b1;
    unique case (op.func)
      cdq_pkg::FN_PUSH_FRONT, cdq_pkg::FN_PUSH_BACK: begin
        if (dq_empty) begin
          // first entry always lands in slot 0
          dq_head     = 0;
          dq_tail     = 0;
          dq_store[0] = op.value;
          dq_empty    = 1'b0;
        end else if (at_capacity(c)) begin
          r.success = 1'b0;
        end else if (op.func == cdq_pkg::FN_PUSH_FRONT) begin
          dq_head           = ring_down(dq_head, c);
          dq_store[dq_head] = op.value;
        end else begin
          dq_tail           = ring_up(dq_tail, c);
          dq_store[dq_tail] = op.value;
        end
      end
      cdq_pkg::FN_POP_FRONT, cdq_pkg::FN_POP_BACK: begin
        if (dq_empty) begin
          r.success = 1'b0;
        end else if (dq_head == dq_tail) begin
          // last entry gone: both pointers back home
          dq_head  = 0;
          dq_tail  = 0;
          dq_empty = 1'b1;
        end else if (op.func == cdq_pkg::FN_POP_FRONT) begin
          dq_head = ring_up(dq_head, c);
        end else begin
          dq_tail = ring_down(dq_tail, c);
        end
      end
      default: ;
    endcase
    r.front_value = dq_empty ? '1 : dq_store[dq_head];
    r.rear_value  = dq_empty ? '1 : dq_store[dq_tail];
    r.is_empty    = dq_empty;
    r.is_full     = at_capacity(c);
    return r;
  endfunction

  function automatic void check_field(string field, logic [VW-1:0] want,
                                      logic [VW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      n_fail++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: at the falling edge, hold a word until it is taken, then offer the
  // next one unless the sender idles this cycle. Result ready is redrawn too.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    op_word_t nxt;
    if (!rst) begin
      if (!op_if.valid || op_taken) begin
        if (pending_ops.size() > 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          nxt = pending_ops.pop_front();
          op_if.valid      <= 1'b1;
          op_if.func       <= nxt.func;
          op_if.item_value <= nxt.value;
        end else begin
          op_if.valid <= 1'b0;
        end
      end
      status_if.ready <= ($urandom_range(99, 0) >= snk_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at the rising edge, predict for every word taken and check every
  // status word handed over against the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : observe
    op_word_t     op;
    status_word_t want;
    if (rst) begin
      op_taken = 1'b0;
    end else begin
      op_taken = op_if.valid && op_if.ready;
      if (op_taken) begin
        op.func  = op_if.func;
        op.value = op_if.item_value;
        status_due.push_back(status_after_op(op));
      end
      if (status_if.valid && status_if.ready) begin
        if (status_due.size() == 0) begin
          $error("status word with no operation outstanding");
          n_fail++;
        end else begin
          want = status_due.pop_front();
          check_field("success", VW'(want.success), VW'(status_if.success));
          check_field("front_value", want.front_value, status_if.front_value);
          check_field("rear_value", want.rear_value, status_if.rear_value);
          check_field("is_empty", VW'(want.is_empty), VW'(status_if.is_empty));
          check_field("is_full", VW'(want.is_full), VW'(status_if.is_full));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_op(logic [FW-1:0] fn, logic [VW-1:0] v);
    op_word_t w;
    w.func  = fn;
    w.value = v;
    pending_ops.push_back(w);
  endtask

  function automatic logic [VW-1:0] pick_value();
    unique case ($urandom_range(15, 0))
      0:       return '0;
      1:       return '1;
      2:       return {1'b0, {(VW-1){1'b1}}};   // most positive
      3:       return {1'b1, {(VW-1){1'b0}}};   // most negative
      default: return $urandom;
    endcase
  endfunction

  // Random operations that swing between filling and draining, so the deque
  // keeps reaching full and empty. A few status and unused codes mixed in.
  task automatic queue_random_ops(int n);
    int fill_pct;
    int run;
    int r;
    fill_pct = 75;
    run      = $urandom_range(40, 8);
    for (int k = 0; k < n; k++) begin
      if (run == 0) begin
        fill_pct = 100 - fill_pct;
        run      = $urandom_range(50, 10);
      end
      run--;
      r = $urandom_range(99, 0);
      if (r < 6)
        queue_op(cdq_pkg::FN_STATUS, pick_value());
      else if (r < 9)
        queue_op(FW'($urandom_range(2**FW - 1, cdq_pkg::FN_STATUS + 1)), pick_value());
      else if ($urandom_range(99, 0) < fill_pct)
        queue_op($urandom_range(1, 0) ? cdq_pkg::FN_PUSH_BACK : cdq_pkg::FN_PUSH_FRONT,
                 pick_value());
      else
        queue_op($urandom_range(1, 0) ? cdq_pkg::FN_POP_BACK : cdq_pkg::FN_POP_FRONT,
                 pick_value());
    end
  endtask

  task automatic set_idling(idle_mode_t m);
    src_idle_pct  = (m == IDLE_SENDER)   ? 67 : (m == IDLE_BOTH) ? 17 : 0;
    snk_stall_pct = (m == IDLE_RECEIVER) ? 67 : (m == IDLE_BOTH) ? 17 : 0;
  endtask

  // nothing left to send, nothing on the wire, nothing outstanding
  task automatic wait_quiet();
    do @(posedge clk);
    while (pending_ops.size() != 0 || op_if.valid || status_due.size() != 0);
  endtask

  // APB write with setup and access phases; the register takes the value at the access edge.
  // Only called while quiet, so the shadow copy can follow right away.
  task automatic write_capacity(logic [CPW-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {cdq_pkg::REG_CAPACITY, 2'b00};
    pwdata  <= DW'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    cap_reg = v;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    logic [CPW-1:0] phase_cap  [9];
    idle_mode_t     phase_idle [9];
    int             phase_len  [9];
    op_if.valid      = 1'b0;
    op_if.func       = cdq_pkg::FN_STATUS;
    op_if.item_value = '0;
    status_if.ready  = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset capacity written back explicitly. Empty-deque status,
    // refused pops and unused codes first; then a full fill that writes every
    // slot (push back from slot 0 up, push front wrapping down from the top),
    // refused pushes on a full deque, and one pop at each end.
    write_capacity(cdq_pkg::CAP_RESET);
    set_idling(IDLE_NONE);
    queue_op(cdq_pkg::FN_STATUS, '0);
    queue_op(cdq_pkg::FN_POP_FRONT, '0);
    queue_op(cdq_pkg::FN_POP_BACK, '0);
    for (int u = cdq_pkg::FN_STATUS + 1; u < 2**FW; u++)
      queue_op(FW'(u), $urandom);
    queue_op(cdq_pkg::FN_PUSH_BACK, 32'h7fff_ffff);
    queue_op(cdq_pkg::FN_PUSH_BACK, 32'h8000_0000);
    queue_op(cdq_pkg::FN_PUSH_BACK, 32'h0000_0000);
    queue_op(cdq_pkg::FN_PUSH_BACK, 32'hffff_ffff);
    queue_op(cdq_pkg::FN_PUSH_BACK, 32'haaaa_aaaa);
    queue_op(cdq_pkg::FN_PUSH_BACK, 32'h5555_5555);
    repeat (DEPTH / 2 - 6) queue_op(cdq_pkg::FN_PUSH_BACK, $urandom);
    repeat (DEPTH / 2) queue_op(cdq_pkg::FN_PUSH_FRONT, $urandom);
    queue_op(cdq_pkg::FN_PUSH_FRONT, 32'h1234_5678);
    queue_op(cdq_pkg::FN_PUSH_BACK, 32'h8765_4321);
    queue_op(cdq_pkg::FN_POP_FRONT, '0);
    queue_op(cdq_pkg::FN_POP_BACK, '0);
    wait_quiet();

    // Random phases. Capacity changes land on whatever the deque holds, which
    // is safe now that every slot has been written. Extremes 1, 0, 31 and 17
    // included; two phases draw a capacity at random.
    phase_cap  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd17, 5'd0, 5'd0, 5'd8};
    phase_idle = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE,
                   IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};
    phase_len  = '{90, 60, 60, 90, 90, 90, 90, 90, 70};
    phase_cap[6] = CPW'($urandom_range(DEPTH - 1, 2));
    phase_cap[7] = CPW'($urandom_range(2**CPW - 1, 0));
    for (int p = 0; p < 9; p++) begin
      repeat (2) @(posedge clk);
      write_capacity(phase_cap[p]);
      set_idling(phase_idle[p]);
      queue_random_ops(phase_len[p]);
      wait_quiet();
    end

    // allow time for any stray status word before the final check
    repeat (4) @(posedge clk);
    if (status_due.size() != 0) begin
      $error("%0d status words never arrived", status_due.size());
      n_fail++;
    end
    if (n_fail == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("== FAIL ==");
    $finish;
  end

endmodule
